>>> sv/sss_pkg.sv
// Package for the SSS chip generator: constants, shared types, the three
// length-31 m-sequences and the table that maps a cell group id to m0 and m1.
// No dependencies.
package sss_pkg;

    localparam int SeqLen     = 31;
    localparam int SubGroup   = 30;
    localparam int ChipCount  = 64;
    localparam int MaxGroup   = 167;
    localparam int MaxSector  = 2;
    localparam int GroupCount = MaxGroup + 1;
    localparam int QueueDepth = 2;
    localparam int DcChip     = 31;
    localparam int LastChip   = ChipCount - 1;

    localparam logic signed [1:0] ChipPlus  = 2'sb01;
    localparam logic signed [1:0] ChipMinus = 2'sb11;
    localparam logic signed [1:0] ChipZero  = 2'sb00;

    typedef logic [4:0] seq_idx_t;
    typedef logic [5:0] chip_idx_t;

    typedef struct packed {
        seq_idx_t   ma;
        seq_idx_t   mb;
        logic [2:0] mz;
        logic [1:0] n2;
    } sss_desc_t;

    typedef struct packed {
        seq_idx_t m0;
        seq_idx_t m1;
    } m_pair_t;

    typedef m_pair_t [GroupCount-1:0] m_table_t;

    function automatic logic [SeqLen-1:0] gen_mseq(input logic [4:0] taps);
        logic [SeqLen-1:0] x;
        logic              fb;
        x    = '0;
        x[4] = 1'b1;
        for (int i = 0; i + 5 < SeqLen; i++)
        begin
            fb = 1'b0;
            for (int t = 0; t < 5; t++)
            begin
                if (taps[t])
                begin
                    fb = fb ^ x[i+t];
                end
            end
            x[i+5] = fb;
        end
        return x;
    endfunction

    function automatic m_table_t build_m_table();
        m_table_t tbl;
        int       qd;
        int       q;
        int       md;
        int       m0;
        int       m1;
        for (int i = 0; i < GroupCount; i++)
        begin
            qd = i / SubGroup;
            q  = (i + qd * (qd + 1) / 2) / SubGroup;
            md = i + q * (q + 1) / 2;
            m0 = md % SeqLen;
            m1 = (m0 + md / SeqLen + 1) % SeqLen;
            tbl[i].m0 = m0[4:0];
            tbl[i].m1 = m1[4:0];
        end
        return tbl;
    endfunction

    localparam logic [SeqLen-1:0] SSeq = gen_mseq(5'h05);
    localparam logic [SeqLen-1:0] CSeq = gen_mseq(5'h09);
    localparam logic [SeqLen-1:0] ZSeq = gen_mseq(5'h17);
    localparam m_table_t MTable = build_m_table();

    // Cyclic index (a + b) mod 31 for a below 31 and b below 31.
    function automatic seq_idx_t idx_add(input seq_idx_t a, input logic [5:0] b);
        logic [6:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        if (sum >= 7'(SeqLen))
        begin
            sum = sum - 7'(SeqLen);
        end
        return sum[4:0];
    endfunction

endpackage

>>> sv/sss_if.sv
// Channel interfaces of the SSS chip generator: the request channel and the
// chip channel, each with valid, ready and payload. Depends on sss_pkg.
interface sss_req_if
    import sss_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] cell_group_id;
    logic [1:0] sector_id;
    logic       second_half;

    modport source (output valid, cell_group_id, sector_id, second_half, input ready);
    modport sink   (input valid, cell_group_id, sector_id, second_half, output ready);
endinterface

interface sss_chip_if
    import sss_pkg::*;
();
    logic              valid;
    logic              ready;
    chip_idx_t         chip_index;
    logic signed [1:0] chip_value;
    logic              last;

    modport source (output valid, chip_index, chip_value, last, input ready);
    modport sink   (input valid, chip_index, chip_value, last, output ready);
endinterface

>>> sv/sss_front.sv
// Request front end: clamps the ids, looks up m0 and m1 and forms the shift
// descriptor for the chip back end. Depends on sss_pkg and sss_if.
module sss_front
    import sss_pkg::*;
(
    sss_req_if.sink   req,
    output logic      push_valid,
    input  logic      push_ready,
    output sss_desc_t push_data
);

    logic [7:0] group_clamped;
    logic [1:0] sector_clamped;
    m_pair_t    pair;

    always_comb
    begin
        group_clamped  = (req.cell_group_id > 8'(MaxGroup)) ? 8'(MaxGroup) : req.cell_group_id;
        sector_clamped = (req.sector_id > 2'(MaxSector)) ? 2'(MaxSector) : req.sector_id;
        pair           = MTable[group_clamped];
        push_data.n2   = sector_clamped;
        if (req.second_half)
        begin
            push_data.ma = pair.m1;
            push_data.mb = pair.m0;
            push_data.mz = pair.m1[2:0];
        end
        else
        begin
            push_data.ma = pair.m0;
            push_data.mb = pair.m1;
            push_data.mz = pair.m0[2:0];
        end
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

>>> sv/sss_fifo.sv
// Short descriptor queue between the front end and the chip back end.
// Depends on sss_pkg.
module sss_fifo
    import sss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  sss_desc_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output sss_desc_t pop_data
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    sss_desc_t         entry_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CntW'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/sss_back.sv
// Chip back end: walks the 64 chip positions of one descriptor and drives
// the chip channel from an output register. Depends on sss_pkg and sss_if.
module sss_back
    import sss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  sss_desc_t   pop_data,
    sss_chip_if.source  chip
);

    chip_idx_t         k_reg;
    chip_idx_t         k_next;
    logic              valid_reg;
    logic              valid_next;
    chip_idx_t         index_reg;
    logic signed [1:0] value_reg;
    logic signed [1:0] value_next;
    logic              last_reg;
    logic              load;
    logic              is_last;
    chip_idx_t         j;
    seq_idx_t          n;
    logic              bit_even;
    logic              bit_odd;
    logic              chip_bit;

    assign load      = pop_valid && (!valid_reg || chip.ready);
    assign is_last   = (k_reg == 6'(LastChip));
    assign pop_ready = load && is_last;

    always_comb
    begin
        j        = (k_reg < 6'(DcChip)) ? k_reg : k_reg - 1'b1;
        n        = j[5:1];
        bit_even = SSeq[idx_add(n, {1'b0, pop_data.ma})]
                 ^ CSeq[idx_add(n, {4'b0, pop_data.n2})];
        bit_odd  = SSeq[idx_add(n, {1'b0, pop_data.mb})]
                 ^ CSeq[idx_add(n, {4'b0, pop_data.n2} + 6'd3)]
                 ^ ZSeq[idx_add(n, {3'b0, pop_data.mz})];
        chip_bit = j[0] ? bit_odd : bit_even;
        if (k_reg == 6'(DcChip) || is_last)
        begin
            value_next = ChipZero;
        end
        else
        begin
            value_next = chip_bit ? ChipMinus : ChipPlus;
        end
        k_next     = load ? k_reg + 1'b1 : k_reg;
        valid_next = load ? 1'b1 : (valid_reg && !chip.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= k_reg;
            value_reg <= value_next;
            last_reg  <= is_last;
        end
    end

    assign chip.valid      = valid_reg;
    assign chip.chip_index = index_reg;
    assign chip.chip_value = value_reg;
    assign chip.last       = last_reg;

endmodule

>>> sv/sss_sequence_generator.sv
// LTE secondary synchronization signal chip generator, top level.
// Each request on req carries a cell group id, a sector id and a half-frame
// select; out-of-range ids are clamped to the largest legal value.
// For each request the block sends 64 chips on chip, in order 0 to 63, each
// with its index, a value of +1 or -1 (0 at DC, chip 31, and at chip 63),
// and last set on chip 63.
// A request accepted into an empty queue passes through the queue entry and
// then the chip output register before its first chip is valid; after that
// one chip leaves per cycle while the receiver holds ready high.
// A two-entry request queue lets new requests be accepted while an earlier
// one is still being sent, so back-to-back requests produce chips with no gap.
// When the receiver holds ready low, the current chip is held and the chip
// counter stops; req.ready falls once the queue is full.
// Reset clears the queue, the chip counter and the output valid.
// Depends on sss_pkg, sss_if, sss_front, sss_fifo and sss_back.
module sss_sequence_generator
    import sss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sss_req_if.sink    req,
    sss_chip_if.source chip
);

    logic      push_valid;
    logic      push_ready;
    sss_desc_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    sss_desc_t pop_data;

    sss_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sss_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .chip       (chip)
    );

endmodule

>>> tb/sv/sss_sequence_generator_tb.sv
// Self-checking testbench for sss_sequence_generator: sends SSS requests and
// checks every chip against a predictor built from the LTE SSS definition.
// Depends on sss_pkg, sss_if and the sss_sequence_generator RTL.
module sss_sequence_generator_tb;
    import sss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ResetCycles   = 8;
    localparam int SettleCycles  = 8;
    localparam int WatchdogLimit = 500;

    typedef struct {
        chip_idx_t         index;
        logic signed [1:0] value;
        logic              last;
    } sss_chip_t;

    logic clk;
    logic rst_n;

    sss_req_if  req_bus();
    sss_chip_if chip_bus();

    sss_chip_t   expected_chips[$];
    int unsigned failures;
    int unsigned stalled_cycles;
    int unsigned req_gap_pct;
    int unsigned ready_stall_pct;

    sss_sequence_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .chip  (chip_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [SeqLen-1:0] lfsr_bits(input logic [4:0] taps);
        logic [SeqLen-1:0] seq;
        seq      = '0;
        seq[4:0] = 5'b10000;
        for (int i = 5; i < SeqLen; i++)
        begin
            seq[i] = ^(seq[i-5 +: 5] & taps);
        end
        return seq;
    endfunction

    function automatic void predict_sss_chips(input logic [7:0] group_in,
                                              input logic [1:0] sector_in,
                                              input logic       half);
        logic [SeqLen-1:0] s_bits;
        logic [SeqLen-1:0] c_bits;
        logic [SeqLen-1:0] z_bits;
        logic [61:0]       d;
        int                n1;
        int                n2;
        int                qd;
        int                q;
        int                md;
        int                m0;
        int                m1;
        int                ma;
        int                mb;
        int                mz;
        int                j;
        sss_chip_t         chip_exp;
        s_bits = lfsr_bits(5'h05);
        c_bits = lfsr_bits(5'h09);
        z_bits = lfsr_bits(5'h17);
        n1 = (int'(group_in) > MaxGroup) ? MaxGroup : int'(group_in);
        n2 = (int'(sector_in) > MaxSector) ? MaxSector : int'(sector_in);
        qd = n1 / SubGroup;
        q  = (n1 + qd * (qd + 1) / 2) / SubGroup;
        md = n1 + q * (q + 1) / 2;
        m0 = md % SeqLen;
        m1 = (m0 + md / SeqLen + 1) % SeqLen;
        ma = half ? m1 : m0;
        mb = half ? m0 : m1;
        mz = (half ? m1 : m0) % 8;
        for (int n = 0; n < SeqLen; n++)
        begin
            d[2*n]   = s_bits[(n + ma) % SeqLen] ^ c_bits[(n + n2) % SeqLen];
            d[2*n+1] = s_bits[(n + mb) % SeqLen] ^ c_bits[(n + n2 + 3) % SeqLen]
                       ^ z_bits[(n + mz) % SeqLen];
        end
        for (int k = 0; k < ChipCount; k++)
        begin
            chip_exp.index = chip_idx_t'(k);
            if (k == DcChip || k == LastChip)
            begin
                chip_exp.value = ChipZero;
            end
            else
            begin
                j = (k < DcChip) ? k : k - 1;
                chip_exp.value = d[j] ? ChipMinus : ChipPlus;
            end
            chip_exp.last = (k == LastChip);
            expected_chips.push_back(chip_exp);
        end
    endfunction

    // Chips are checked before a request accepted at the same edge is
    // predicted; such a request cannot have produced a chip yet.
    always @(posedge clk)
    begin
        sss_chip_t want;
        if (chip_bus.valid && chip_bus.ready)
        begin
            if (expected_chips.size() == 0)
            begin
                failures++;
                $error("unexpected chip: chip_index %0d, chip_value %0d, last %0b",
                       chip_bus.chip_index, chip_bus.chip_value, chip_bus.last);
            end
            else
            begin
                want = expected_chips.pop_front();
                if (chip_bus.chip_index !== want.index)
                begin
                    failures++;
                    $error("chip_index: expected %0d, got %0d",
                           want.index, chip_bus.chip_index);
                end
                if (chip_bus.chip_value !== want.value)
                begin
                    failures++;
                    $error("chip_value at chip %0d: expected %0d, got %0d",
                           want.index, want.value, chip_bus.chip_value);
                end
                if (chip_bus.last !== want.last)
                begin
                    failures++;
                    $error("last at chip %0d: expected %0b, got %0b",
                           want.index, want.last, chip_bus.last);
                end
            end
        end
        if (req_bus.valid && req_bus.ready)
        begin
            predict_sss_chips(req_bus.cell_group_id, req_bus.sector_id,
                              req_bus.second_half);
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (chip_bus.valid && chip_bus.ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= WatchdogLimit)
        begin
            $display("sss_sequence_generator_tb NOT OK");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    always
    begin
        @(negedge clk);
        if ($urandom_range(0, 99) < ready_stall_pct)
        begin
            chip_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        chip_bus.ready <= 1'b1;
    end

    task automatic send_request(input logic [7:0] group_id,
                                input logic [1:0] sector,
                                input logic       half);
        @(negedge clk);
        if ($urandom_range(0, 99) < req_gap_pct)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.cell_group_id <= group_id;
        req_bus.sector_id     <= sector;
        req_bus.second_half   <= half;
        do
        begin
            @(posedge clk);
        end
        while (!req_bus.ready);
    endtask

    task automatic wait_for_chips();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (expected_chips.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic send_random_request();
        logic [7:0] group_id;
        if ($urandom_range(0, 99) < 80)
        begin
            group_id = 8'($urandom_range(0, MaxGroup));
        end
        else
        begin
            group_id = 8'($urandom_range(0, 255));
        end
        send_request(group_id, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_group_extremes();
        req_gap_pct     = 30;
        ready_stall_pct = 30;
        send_request(8'd0, 2'd0, 1'b0);
        send_request(8'd0, 2'd0, 1'b1);
        send_request(8'd167, 2'd2, 1'b0);
        send_request(8'd167, 2'd2, 1'b1);
        send_request(8'd29, 2'd1, 1'b0);
        send_request(8'd30, 2'd1, 1'b1);
        send_request(8'd31, 2'd0, 1'b0);
        send_request(8'd60, 2'd2, 1'b1);
        send_request(8'd100, 2'd1, 1'b0);
    endtask

    task automatic test_clamping();
        send_request(8'd168, 2'd0, 1'b0);
        send_request(8'd255, 2'd3, 1'b1);
        send_request(8'd200, 2'd3, 1'b0);
        send_request(8'd0, 2'd3, 1'b1);
        send_request(8'd170, 2'd1, 1'b1);
        send_request(8'd128, 2'd2, 1'b0);
    endtask

    // The sender stops until every chip of the earlier requests is out.
    task automatic test_drain_pause();
        repeat (4) send_random_request();
        wait_for_chips();
    endtask

    task automatic test_random_requests();
        for (int i = 0; i < 180; i++)
        begin
            if (i % 40 == 0)
            begin
                req_gap_pct     = (i % 80 == 0) ? 40 : 0;
                ready_stall_pct = (i % 120 == 40) ? 0 : 25 + 10 * (i % 3);
            end
            send_random_request();
        end
    endtask

    task automatic test_back_to_back();
        req_gap_pct     = 0;
        ready_stall_pct = 0;
        repeat (30) send_random_request();
    endtask

    initial
    begin
        failures              = 0;
        stalled_cycles        = 0;
        req_gap_pct           = 0;
        ready_stall_pct       = 0;
        rst_n                 = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.cell_group_id = '0;
        req_bus.sector_id     = '0;
        req_bus.second_half   = 1'b0;
        chip_bus.ready        = 1'b0;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_group_extremes();
        test_clamping();
        test_drain_pause();
        test_random_requests();
        test_back_to_back();
        wait_for_chips();

        if (failures == 0)
        begin
            $display("sss_sequence_generator_tb OK");
        end
        else
        begin
            $display("sss_sequence_generator_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
sv/sss_pkg.sv
sv/sss_if.sv
sv/sss_front.sv
sv/sss_fifo.sv
sv/sss_back.sv
sv/sss_sequence_generator.sv
tb/sv/sss_sequence_generator_tb.sv
